// File: hdl/vpf_pkg.sv
// ----------------------------------------------------------------------------
// vpf_pkg
// Shared types and constants for the visited proximity filter.
// ----------------------------------------------------------------------------
`default_nettype none

package vpf_pkg;

    localparam int S_DATA_W = 32;
    localparam int S_USER_W = 2;
    localparam int M_DATA_W = 40;

    localparam int COORD_W  = 16;
    localparam int CUTOFF_W = 14;
    localparam int LIM_W    = 2 * CUTOFF_W;
    localparam int SQ_W     = 2 * COORD_W;
    localparam int SUM_W    = SQ_W + 1;

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    localparam logic [CUTOFF_W-1:0] CUTOFF_RESET = CUTOFF_W'(160);
    localparam logic                REG_CUTOFF   = 1'b0;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_TEST  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct packed {
        logic load;
        logic clear;
        logic start;
        logic step;
        logic out_load;
    } vpf_cmd_t;

    typedef struct packed {
        logic empty;
        logic scan_last;
        logic busy;
    } vpf_status_t;

endpackage

`default_nettype wire

// File: hdl/vpf_cfg.sv
// ----------------------------------------------------------------------------
// vpf_cfg
// APB register slave holding the cutoff distance.
// ----------------------------------------------------------------------------
`default_nettype none

module vpf_cfg (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [vpf_pkg::APB_AW-1:0]   paddr,
    input  wire logic [vpf_pkg::APB_DW-1:0]   pwdata,
    output logic      [vpf_pkg::APB_DW-1:0]   prdata,
    output logic                              pready,
    output logic      [vpf_pkg::CUTOFF_W-1:0] cutoff
);
    import vpf_pkg::*;

    logic [CUTOFF_W-1:0] cutoff_reg;
    logic                wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready && (paddr[2] == REG_CUTOFF);
    assign cutoff = cutoff_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cutoff_reg <= CUTOFF_RESET;
        end
        else if (wr_en)
        begin
            cutoff_reg <= pwdata[CUTOFF_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_CUTOFF)
        begin
            prdata = APB_DW'(cutoff_reg);
        end
    end

endmodule

`default_nettype wire

// File: hdl/vpf_dp.sv
// ----------------------------------------------------------------------------
// vpf_dp
// Datapath: visited point store, distance pipeline and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module vpf_dp #(
    parameter int MAX_VISITED = 1024
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire vpf_pkg::vpf_cmd_t            cmd,
    output vpf_pkg::vpf_status_t              status,
    input  wire logic [vpf_pkg::S_DATA_W-1:0] in_data,
    input  wire logic [vpf_pkg::CUTOFF_W-1:0] cutoff,
    output logic      [vpf_pkg::M_DATA_W-1:0] out_data
);
    import vpf_pkg::*;

    localparam int AW = (MAX_VISITED > 1) ? $clog2(MAX_VISITED) : 1;
    localparam int CW = $clog2(MAX_VISITED + 1);

    logic [2*COORD_W-1:0] mem [MAX_VISITED];

    logic [CW-1:0]        count_reg;
    logic                 overflow_reg;
    logic [AW-1:0]        scan_addr_reg;
    coord_t               cand_x_reg, cand_y_reg;
    logic [LIM_W-1:0]     lim_reg;
    logic                 hit_reg;

    logic                 v1_reg, v2_reg, v3_reg, v4_reg;
    logic [2*COORD_W-1:0] rd_data_reg;
    logic signed [COORD_W:0] dx_reg, dy_reg;
    logic [SQ_W-1:0]      sqx_reg, sqy_reg;
    logic [SUM_W-1:0]     sum_reg;

    logic                 keep_reg, ovf_out_reg;
    coord_t               out_x_reg, out_y_reg;

    coord_t               in_x, in_y, mem_x, mem_y;
    logic [COORD_W-1:0]   abs_x, abs_y;
    logic                 full;

    assign in_x  = in_data[COORD_W-1:0];
    assign in_y  = in_data[2*COORD_W-1:COORD_W];
    assign mem_x = rd_data_reg[COORD_W-1:0];
    assign mem_y = rd_data_reg[2*COORD_W-1:COORD_W];
    assign full  = (count_reg == CW'(MAX_VISITED));
    assign abs_x = dx_reg[COORD_W] ? COORD_W'(-dx_reg) : dx_reg[COORD_W-1:0];
    assign abs_y = dy_reg[COORD_W] ? COORD_W'(-dy_reg) : dy_reg[COORD_W-1:0];

    assign status.empty     = (count_reg == '0);
    assign status.scan_last = (CW'(scan_addr_reg) == count_reg - CW'(1));
    assign status.busy      = v1_reg || v2_reg || v3_reg || v4_reg;

    assign out_data = {(M_DATA_W - 2 - 2*COORD_W)'(0), ovf_out_reg, out_y_reg, out_x_reg,
                       keep_reg};

    // store
    always_ff @(posedge clk)
    begin
        if (cmd.load && !full)
        begin
            mem[count_reg[AW-1:0]] <= {in_y, in_x};
        end
        if (cmd.step)
        begin
            rd_data_reg <= mem[scan_addr_reg];
        end
    end

    // control state of the datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            overflow_reg  <= 1'b0;
            scan_addr_reg <= '0;
            hit_reg       <= 1'b0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                if (full)
                begin
                    overflow_reg <= 1'b1;
                end
                else
                begin
                    count_reg <= count_reg + CW'(1);
                end
            end
            if (cmd.clear)
            begin
                count_reg <= '0;
            end
            if (cmd.start)
            begin
                scan_addr_reg <= '0;
            end
            else if (cmd.step)
            begin
                scan_addr_reg <= scan_addr_reg + AW'(1);
            end
            if (cmd.start)
            begin
                hit_reg <= 1'b0;
            end
            else if (v4_reg && (sum_reg <= SUM_W'(lim_reg)))
            begin
                hit_reg <= 1'b1;
            end
            v1_reg <= cmd.step;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // distance pipeline and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            cand_x_reg <= in_x;
            cand_y_reg <= in_y;
            lim_reg    <= LIM_W'(cutoff) * LIM_W'(cutoff);
        end
        dx_reg  <= (COORD_W+1)'(mem_x) - (COORD_W+1)'(cand_x_reg);
        dy_reg  <= (COORD_W+1)'(mem_y) - (COORD_W+1)'(cand_y_reg);
        sqx_reg <= SQ_W'(abs_x) * SQ_W'(abs_x);
        sqy_reg <= SQ_W'(abs_y) * SQ_W'(abs_y);
        sum_reg <= SUM_W'(sqx_reg) + SUM_W'(sqy_reg);
        if (cmd.out_load)
        begin
            keep_reg    <= status.empty || !hit_reg;
            out_x_reg   <= cand_x_reg;
            out_y_reg   <= cand_y_reg;
            ovf_out_reg <= overflow_reg;
        end
    end

endmodule

`default_nettype wire

// File: hdl/vpf_ctrl.sv
// ----------------------------------------------------------------------------
// vpf_ctrl
// Controller: stream handshakes and sequencing of the store scan.
// ----------------------------------------------------------------------------
`default_nettype none

module vpf_ctrl (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [vpf_pkg::S_USER_W-1:0] s_tuser,
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output vpf_pkg::vpf_cmd_t                 cmd,
    input  wire vpf_pkg::vpf_status_t         status
);
    import vpf_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (s_tuser)
                        OP_LOAD:  cmd.load  = 1'b1;
                        OP_CLEAR: cmd.clear = 1'b1;
                        OP_TEST:
                        begin
                            cmd.start  = 1'b1;
                            state_next = status.empty ? ST_EMIT : ST_SCAN;
                        end
                        default: ;
                    endcase
                end
            end
            ST_SCAN:
            begin
                cmd.step = 1'b1;
                if (status.scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!status.busy)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

// File: hdl/visited_proximity_filter.sv
// ----------------------------------------------------------------------------
// visited_proximity_filter
// Keeps candidate 2D points that lie farther than a cutoff from all visited points.
// ----------------------------------------------------------------------------
// Load and clear beats are taken in the idle state. A test beat scans the whole
// store unless the store is empty. The store has a single read port, so
// stored points are streamed one per cycle through a four-stage squared-distance
// pipeline, then the result is written to the output register. Tests are served
// one at a time; a finished result waits in the output register while load,
// clear and the next test beats are taken. No clearing pass follows reset.
`default_nettype none

module visited_proximity_filter #(
    parameter int MAX_VISITED = 1024
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [vpf_pkg::S_DATA_W-1:0] s_tdata,  // x_pos, y_pos
    input  wire logic [vpf_pkg::S_USER_W-1:0] s_tuser,  // operation
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic      [vpf_pkg::M_DATA_W-1:0] m_tdata,  // keep, out_x, out_y, overflowed
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [vpf_pkg::APB_AW-1:0]   paddr,
    input  wire logic [vpf_pkg::APB_DW-1:0]   pwdata,
    output logic      [vpf_pkg::APB_DW-1:0]   prdata,
    output logic                              pready
);
    import vpf_pkg::*;

    vpf_cmd_t            cmd;
    vpf_status_t         status;
    logic [CUTOFF_W-1:0] cutoff;

    vpf_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cutoff  (cutoff)
    );

    vpf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .status   (status)
    );

    vpf_dp #(
        .MAX_VISITED (MAX_VISITED)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .status   (status),
        .in_data  (s_tdata),
        .cutoff   (cutoff),
        .out_data (m_tdata)
    );

endmodule

`default_nettype wire

// File: hdl/vpf_checker.sv
// ----------------------------------------------------------------------------
// vpf_checker
// Port-level checks for the visited proximity filter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module vpf_checker (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         s_tvalid,
    input  wire logic                         s_tready,
    input  wire logic [vpf_pkg::S_USER_W-1:0] s_tuser,
    input  wire logic                         m_tvalid,
    input  wire logic                         m_tready,
    input  wire logic [vpf_pkg::M_DATA_W-1:0] m_tdata,
    input  wire logic                         psel,
    input  wire logic                         pwrite,
    input  wire logic [vpf_pkg::APB_AW-1:0]   paddr,
    input  wire logic [vpf_pkg::APB_DW-1:0]   prdata
);
    import vpf_pkg::*;

    a_m_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result beat dropped while stalled");

    a_m_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result beat changed while stalled");

    a_test_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == OP_TEST) |=> !s_tready)
        else $error("input taken in the cycle after a test beat");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[M_DATA_W-1:2*COORD_W+2] == '0))
        else $error("result padding bits not zero");

    a_rd_width: assert property (@(posedge clk) disable iff (!rst_n)
        psel && !pwrite && (paddr[2] == REG_CUTOFF) |-> (prdata[APB_DW-1:CUTOFF_W] == '0))
        else $error("cutoff readback wider than register");

endmodule

bind visited_proximity_filter vpf_checker u_vpf_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .prdata   (prdata)
);

`default_nettype wire
